@@ sv/bpv7_payload_block_parser_unit_assert.svh @@
// Assertion macros used by the payload block parser checker.
// No dependencies; include by bare file name.
`ifndef BPV7_PAYLOAD_BLOCK_PARSER_UNIT_ASSERT_SVH
`define BPV7_PAYLOAD_BLOCK_PARSER_UNIT_ASSERT_SVH

// clocked property, masked while reset is high
`define BPV7PB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bpv7pb assertion failed");

// clocked property, checked during reset too
`define BPV7PB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bpv7pb assertion failed");

`endif

@@ sv/bpv7pb_pkg.sv @@
// Types, codes and helpers for the BPv7 payload block parser.
// No dependencies; imported by the parser and its checker.
`default_nettype none

package bpv7pb_pkg;

   typedef enum logic [2:0] {
      PH_HEAD,
      PH_ARG,
      PH_PAYLOAD,
      PH_CRC,
      PH_BREAK
   } phase_type;

   // result kinds
   localparam logic [2:0] KIND_HDR      = 3'd0;
   localparam logic [2:0] KIND_HDR_DONE = 3'd1;
   localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
   localparam logic [2:0] KIND_CRC      = 3'd3;
   localparam logic [2:0] KIND_END      = 3'd4;
   localparam logic [2:0] KIND_ERR      = 3'd5;

   // CBOR major types
   localparam logic [2:0] MAJOR_UINT  = 3'd0;
   localparam logic [2:0] MAJOR_BYTES = 3'd2;
   localparam logic [2:0] MAJOR_ARRAY = 3'd4;

   // CBOR additional info limits
   localparam logic [4:0] AI_ONE_BYTE  = 5'd24;
   localparam logic [4:0] AI_EIGHT_BYTE = 5'd27;

   // header field slots
   localparam logic [2:0] FLD_COUNT   = 3'd0;
   localparam logic [2:0] FLD_TYPE    = 3'd1;
   localparam logic [2:0] FLD_NUMBER  = 3'd2;
   localparam logic [2:0] FLD_FLAGS   = 3'd3;
   localparam logic [2:0] FLD_CRC     = 3'd4;
   localparam logic [2:0] FLD_PAYLOAD = 3'd5;

   localparam logic [1:0] CRC_NONE   = 2'd0;
   localparam logic [1:0] CRC_16     = 2'd1;
   localparam logic [1:0] CRC_32C    = 2'd2;

   localparam logic [7:0] CBOR_BREAK          = 8'hff;
   localparam logic [7:0] EXP_TYPE_RESET      = 8'd1;
   localparam logic [2:0] ELEMS_NO_CRC        = 3'd5;
   localparam logic [2:0] ELEMS_WITH_CRC      = 3'd6;
   localparam logic [5:0] MIN_HEADER_BYTES    = 6'd6;

   function automatic logic [2:0] trailer_of(input logic [1:0] crc);
      logic [2:0] len;
      case (crc)
         CRC_16:  len = 3'd3;
         CRC_32C: len = 3'd5;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

@@ sv/bpv7_payload_block_parser_unit.sv @@
// The result of an accepted request byte is registered and valid in the next cycle.
// Throughput: one byte per cycle; the only stall is a held result register.
// Every request gives exactly one result; error or end of block restarts parsing.
// Reset (synchronous, active high) returns to awaiting the array head and sets
// the expected block type to one.
`default_nettype none

module bpv7_payload_block_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [63:0]      rsp_block_number,
   output logic [1:0]       rsp_crc_kind,
   output logic [63:0]      rsp_payload_length,
   output logic [5:0]       rsp_header_length,
   output logic [2:0]       rsp_trailer_length,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_expected_block_type
);
   import bpv7pb_pkg::*;

   logic [7:0]  exp_type_ff;

   phase_type   phase_ff, phase_in;
   logic [2:0]  elem_cnt_ff, elem_cnt_in;
   logic [2:0]  field_idx_ff, field_idx_in;
   logic [3:0]  arg_left_ff, arg_left_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] blk_num_ff, blk_num_in;
   logic [1:0]  crc_kind_ff, crc_kind_in;
   logic [63:0] pay_left_ff, pay_left_in;
   logic [63:0] pay_len_ff, pay_len_in;
   logic [2:0]  crc_left_ff, crc_left_in;
   logic [5:0]  hdr_cnt_ff, hdr_cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff;
   logic [7:0]  rsp_data_ff;
   logic [63:0] rsp_blk_num_ff;
   logic [1:0]  rsp_crc_kind_ff;
   logic [63:0] rsp_pay_len_ff;
   logic [5:0]  rsp_hdr_len_ff;
   logic [2:0]  rsp_trl_len_ff;

   logic        accept;
   logic        restart;
   logic [2:0]  kind;
   logic [2:0]  major;
   logic [4:0]  ai;
   logic [2:0]  need;
   logic        fin;
   logic [63:0] fin_val;

   assign csr_ready    = 1'b1;
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   assign major = req_in_byte[7:5];
   assign ai    = req_in_byte[4:0];
   assign need  = (field_idx_ff == FLD_COUNT)   ? MAJOR_ARRAY :
                  (field_idx_ff == FLD_PAYLOAD) ? MAJOR_BYTES : MAJOR_UINT;

   always_comb begin
      phase_in    = phase_ff;
      elem_cnt_in = elem_cnt_ff;
      field_idx_in = field_idx_ff;
      arg_left_in = arg_left_ff;
      acc_in      = acc_ff;
      blk_num_in  = blk_num_ff;
      crc_kind_in = crc_kind_ff;
      pay_left_in = pay_left_ff;
      pay_len_in  = pay_len_ff;
      crc_left_in = crc_left_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      kind        = KIND_ERR;
      fin         = 1'b0;
      fin_val     = '0;

      case (phase_ff)
         PH_HEAD: begin
            hdr_cnt_in = hdr_cnt_ff + 6'd1;
            if (field_idx_ff > FLD_PAYLOAD || major != need || ai > AI_EIGHT_BYTE) begin
               kind = KIND_ERR;
            end else if (ai < AI_ONE_BYTE) begin
               fin     = 1'b1;
               fin_val = {59'd0, ai};
            end else begin
               // 24..27 -> 1, 2, 4, 8 argument bytes
               arg_left_in = 4'd1 << ai[1:0];
               acc_in      = '0;
               phase_in    = PH_ARG;
               kind        = KIND_HDR;
            end
         end
         PH_ARG: begin
            hdr_cnt_in  = hdr_cnt_ff + 6'd1;
            acc_in      = {acc_ff[55:0], req_in_byte};
            arg_left_in = (arg_left_ff != 4'd0) ? arg_left_ff - 4'd1 : arg_left_ff;
            if (arg_left_in == 4'd0) begin
               fin     = 1'b1;
               fin_val = acc_in;
            end else begin
               kind = KIND_HDR;
            end
         end
         PH_PAYLOAD: begin
            kind        = KIND_PAYLOAD;
            pay_left_in = (pay_left_ff != 64'd0) ? pay_left_ff - 64'd1 : pay_left_ff;
            if (pay_left_in == 64'd0) begin
               phase_in = (crc_left_ff != 3'd0) ? PH_CRC : PH_BREAK;
            end
         end
         PH_CRC: begin
            kind        = KIND_CRC;
            crc_left_in = (crc_left_ff != 3'd0) ? crc_left_ff - 3'd1 : crc_left_ff;
            if (crc_left_in == 3'd0) begin
               phase_in = PH_BREAK;
            end
         end
         PH_BREAK: begin
            kind = (req_in_byte == CBOR_BREAK) ? KIND_END : KIND_ERR;
         end
         default: begin
            kind = KIND_ERR;
         end
      endcase

      // element value complete: check and store it
      if (fin) begin
         kind = KIND_HDR;
         case (field_idx_ff)
            FLD_COUNT: begin
               if (fin_val != {61'd0, ELEMS_NO_CRC} && fin_val != {61'd0, ELEMS_WITH_CRC}) begin
                  kind = KIND_ERR;
               end else begin
                  elem_cnt_in = fin_val[2:0];
               end
            end
            FLD_TYPE: begin
               if (fin_val != {56'd0, exp_type_ff}) begin
                  kind = KIND_ERR;
               end
            end
            FLD_NUMBER: begin
               blk_num_in = fin_val;
            end
            FLD_FLAGS: begin
               kind = KIND_HDR;
            end
            FLD_CRC: begin
               if (fin_val > {62'd0, CRC_32C}) begin
                  kind = KIND_ERR;
               end else begin
                  // crc type is kept even when the element count mismatches
                  crc_kind_in = fin_val[1:0];
                  if (elem_cnt_ff != ((fin_val == 64'd0) ? ELEMS_NO_CRC : ELEMS_WITH_CRC)) begin
                     kind = KIND_ERR;
                  end else begin
                     crc_left_in = trailer_of(fin_val[1:0]);
                  end
               end
            end
            FLD_PAYLOAD: begin
               pay_len_in  = fin_val;
               pay_left_in = fin_val;
               kind        = KIND_HDR_DONE;
               if (fin_val != 64'd0) begin
                  phase_in = PH_PAYLOAD;
               end else if (crc_left_ff != 3'd0) begin
                  phase_in = PH_CRC;
               end else begin
                  phase_in = PH_BREAK;
               end
            end
            default: begin
               kind = KIND_ERR;
            end
         endcase
         if (kind == KIND_HDR) begin
            field_idx_in = field_idx_ff + 3'd1;
            phase_in     = PH_HEAD;
         end
      end
   end

   assign restart = (kind == KIND_ERR) || (kind == KIND_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_type_ff <= EXP_TYPE_RESET;
      end else if (csr_valid && csr_ready) begin
         exp_type_ff <= csr_expected_block_type;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && restart)) begin
         phase_ff     <= PH_HEAD;
         elem_cnt_ff  <= '0;
         field_idx_ff <= '0;
         arg_left_ff  <= '0;
         acc_ff       <= '0;
         blk_num_ff   <= '0;
         crc_kind_ff  <= '0;
         pay_left_ff  <= '0;
         pay_len_ff   <= '0;
         crc_left_ff  <= '0;
         hdr_cnt_ff   <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         elem_cnt_ff  <= elem_cnt_in;
         field_idx_ff <= field_idx_in;
         arg_left_ff  <= arg_left_in;
         acc_ff       <= acc_in;
         blk_num_ff   <= blk_num_in;
         crc_kind_ff  <= crc_kind_in;
         pay_left_ff  <= pay_left_in;
         pay_len_ff   <= pay_len_in;
         crc_left_ff  <= crc_left_in;
         hdr_cnt_ff   <= hdr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result carries the values before any restart
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_kind_ff     <= kind;
         rsp_data_ff     <= req_in_byte;
         rsp_blk_num_ff  <= blk_num_in;
         rsp_crc_kind_ff <= crc_kind_in;
         rsp_pay_len_ff  <= pay_len_in;
         rsp_hdr_len_ff  <= hdr_cnt_in;
         rsp_trl_len_ff  <= trailer_of(crc_kind_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_data_byte      = rsp_data_ff;
   assign rsp_block_number   = rsp_blk_num_ff;
   assign rsp_crc_kind       = rsp_crc_kind_ff;
   assign rsp_payload_length = rsp_pay_len_ff;
   assign rsp_header_length  = rsp_hdr_len_ff;
   assign rsp_trailer_length = rsp_trl_len_ff;

endmodule

`default_nettype wire

@@ sv/bpv7pb_checker.sv @@
// Port-level checker for the BPv7 payload block parser, bound to the top level.
// Depends on bpv7pb_pkg and bpv7_payload_block_parser_unit_assert.svh.
`default_nettype none
`include "bpv7_payload_block_parser_unit_assert.svh"

module bpv7pb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_kind,
   input wire logic [1:0]  rsp_crc_kind,
   input wire logic [63:0] rsp_payload_length,
   input wire logic [5:0]  rsp_header_length,
   input wire logic [2:0]  rsp_trailer_length
);
   import bpv7pb_pkg::*;

   // a held result keeps its kind
   `BPV7PB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind))

   // every accepted request yields a result next cycle
   `BPV7PB_ASSERT(a_req_to_rsp, clock, reset, req_valid && !req_stall |=> rsp_valid)

   // payload bytes only follow a nonzero declared length
   `BPV7PB_ASSERT(a_payload_len, clock, reset, rsp_valid && rsp_kind == KIND_PAYLOAD |-> rsp_payload_length != 64'd0)

   // smallest header is the array head plus five one-byte heads
   `BPV7PB_ASSERT(a_hdr_len, clock, reset, rsp_valid && rsp_kind == KIND_HDR_DONE |-> rsp_header_length >= MIN_HEADER_BYTES)

   // trailer length follows the crc type, which is never 3
   `BPV7PB_ASSERT(a_trailer, clock, reset, rsp_valid |-> rsp_trailer_length == trailer_of(rsp_crc_kind) && rsp_crc_kind != 2'd3)

endmodule

bind bpv7_payload_block_parser_unit bpv7pb_checker u_bpv7pb_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_crc_kind       (rsp_crc_kind),
   .rsp_payload_length (rsp_payload_length),
   .rsp_header_length  (rsp_header_length),
   .rsp_trailer_length (rsp_trailer_length)
);

`default_nettype wire
